// ===== design/rmv_pkg.sv =====
// rmv_pkg: shared constants for the running mean / variance block.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package rmv_pkg;

	localparam int DATA_WIDTH_DEF  = 32;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;
	localparam int M2_WIDTH        = 63;

	localparam logic [M2_WIDTH-1:0] M2_MAX = '1;

endpackage

`default_nettype wire

// ===== design/rmv_if.sv =====
// rmv_in_if / rmv_out_if: valid/ready channels for samples and statistics.
// Depends on rmv_pkg for default widths.
`default_nettype none

interface rmv_in_if #(
	parameter int DATA_WIDTH = rmv_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample;
	logic                         restart;

	modport source(output valid, sample, restart, input ready);
	modport sink(input valid, sample, restart, output ready);
endinterface

interface rmv_out_if #(
	parameter int DATA_WIDTH  = rmv_pkg::DATA_WIDTH_DEF,
	parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF
);
	logic                             valid;
	logic                             ready;
	logic        [COUNT_WIDTH-1:0]    count;
	logic signed [DATA_WIDTH-1:0]     mean;
	logic        [rmv_pkg::M2_WIDTH-1:0] sq_dev_sum;

	modport source(output valid, count, mean, sq_dev_sum, input ready);
	modport sink(input valid, count, mean, sq_dev_sum, output ready);
endinterface

`default_nettype wire

// ===== design/running_mean_variance.sv =====
// running_mean_variance: Welford online count / mean / M2 over Q16.16 samples.
// Depends on rmv_pkg and the rmv_in_if / rmv_out_if channel interfaces.
//
// One sample is taken at a time. Each sample runs through restoring division
// (delta / count), the mean update (ST_MEAN) and deviation step (ST_MAG),
// shift-add multiplication (delta * deviation) and a saturating M2 update;
// the division and the multiplication share a single adder/subtractor.
// The result sits in an output register, so the next sample can be taken
// while the previous result waits; a result is only held back when the one
// before it has not been transferred yet.
`default_nettype none

module running_mean_variance #(
	parameter int DATA_WIDTH  = rmv_pkg::DATA_WIDTH_DEF,
	parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rmv_in_if.sink    data,
	rmv_out_if.source result
);
	import rmv_pkg::*;

	localparam int W  = ((DATA_WIDTH + 1 > COUNT_WIDTH) ? DATA_WIDTH + 1 : COUNT_WIDTH) + 1;
	localparam int SW = $clog2(DATA_WIDTH + 1);
	localparam int PW = 2 * DATA_WIDTH + 2;
	localparam int EW = (PW - FRAC_BITS > M2_WIDTH) ? PW - FRAC_BITS : M2_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MEAN,
		ST_MAG,
		ST_MUL,
		ST_ACC
	} state_t;

	state_t                       state_q;
	logic        [SW-1:0]         step_q;
	logic        [COUNT_WIDTH-1:0] cnt_q;
	logic signed [DATA_WIDTH-1:0] mean_q;
	logic        [M2_WIDTH-1:0]   m2_q;
	logic signed [DATA_WIDTH-1:0] smp_q;
	logic                         neg_q;
	logic        [DATA_WIDTH:0]   mag_q;
	logic        [W-1:0]          opa_q;
	logic        [DATA_WIDTH:0]   opb_q;

	logic                         ovalid_q;
	logic        [COUNT_WIDTH-1:0] ocount_q;
	logic signed [DATA_WIDTH-1:0] omean_q;
	logic        [M2_WIDTH-1:0]   om2_q;

	// shared adder / subtractor
	logic [W-1:0] add_x;
	logic [W-1:0] add_y;
	logic         add_sub;
	logic [W:0]   add_sum;

	always_comb begin
		if (state_q == ST_DIV) begin
			add_x   = {opa_q[W-2:0], opb_q[DATA_WIDTH]};
			add_y   = W'(cnt_q);
			add_sub = 1'b1;
		end else begin
			add_x   = opa_q;
			add_y   = W'(mag_q);
			add_sub = 1'b0;
		end
		add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {{W{1'b0}}, add_sub};
	end

	// accept-time terms
	logic                         in_xfer;
	logic                         out_xfer;
	logic                         acc_fire;
	logic        [COUNT_WIDTH-1:0] cnt_base;
	logic        [COUNT_WIDTH-1:0] cnt_new;
	logic signed [DATA_WIDTH-1:0] mean_base;
	logic signed [DATA_WIDTH:0]   delta;
	logic        [DATA_WIDTH:0]   delta_mag;

	assign in_xfer   = data.valid && data.ready;
	assign out_xfer  = result.valid && result.ready;
	assign acc_fire  = (state_q == ST_ACC) && (!ovalid_q || result.ready);
	assign cnt_base  = data.restart ? '0 : cnt_q;
	assign cnt_new   = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
	assign mean_base = data.restart ? '0 : mean_q;
	assign delta     = {data.sample[DATA_WIDTH-1], data.sample}
	                 - {mean_base[DATA_WIDTH-1], mean_base};
	assign delta_mag = delta[DATA_WIDTH] ? (DATA_WIDTH+1)'(-delta) : (DATA_WIDTH+1)'(delta);

	// mean update and second deviation
	logic signed [DATA_WIDTH+1:0] quo_ext;
	logic signed [DATA_WIDTH+1:0] mean_next;
	logic signed [DATA_WIDTH:0]   dev2;
	logic        [DATA_WIDTH:0]   dev2_mag;

	assign quo_ext   = neg_q ? -$signed({1'b0, opb_q}) : $signed({1'b0, opb_q});
	assign mean_next = {{2{mean_q[DATA_WIDTH-1]}}, mean_q} + quo_ext;
	assign dev2      = {smp_q[DATA_WIDTH-1], smp_q} - {mean_q[DATA_WIDTH-1], mean_q};
	assign dev2_mag  = dev2[DATA_WIDTH] ? (DATA_WIDTH+1)'(-dev2) : (DATA_WIDTH+1)'(dev2);

	// multiply step
	logic [W-1:0] hi_next;
	assign hi_next = opb_q[0] ? add_sum[W-1:0] : opa_q;

	// M2 accumulate
	logic [PW-1:0]       prod;
	logic [EW-1:0]       inc_w;
	logic [M2_WIDTH-1:0] inc_sat;
	logic [M2_WIDTH:0]   m2_sum;
	logic [M2_WIDTH-1:0] m2_new;

	assign prod    = {opa_q[DATA_WIDTH:0], opb_q};
	assign inc_w   = EW'(prod >> FRAC_BITS);
	assign inc_sat = (inc_w > EW'(M2_MAX)) ? M2_MAX : inc_w[M2_WIDTH-1:0];
	assign m2_sum  = {1'b0, m2_q} + {1'b0, inc_sat};
	assign m2_new  = m2_sum[M2_WIDTH] ? M2_MAX : m2_sum[M2_WIDTH-1:0];

	logic step_last;
	assign step_last = (step_q == SW'(DATA_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			mean_q   <= '0;
			m2_q     <= '0;
			smp_q    <= '0;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			opa_q    <= '0;
			opb_q    <= '0;
			ovalid_q <= 1'b0;
			ocount_q <= '0;
			omean_q  <= '0;
			om2_q    <= '0;
		end else begin
			ovalid_q <= acc_fire || (ovalid_q && !out_xfer);
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= cnt_new;
						mean_q  <= mean_base;
						if (data.restart) begin
							m2_q <= '0;
						end
						smp_q   <= data.sample;
						neg_q   <= delta[DATA_WIDTH];
						mag_q   <= delta_mag;
						opa_q   <= '0;
						opb_q   <= delta_mag;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					opa_q  <= add_sum[W] ? add_sum[W-1:0] : add_x;
					opb_q  <= {opb_q[DATA_WIDTH-1:0], add_sum[W]};
					step_q <= step_q + 1'b1;
					if (step_last) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					mean_q  <= mean_next[DATA_WIDTH-1:0];
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					opa_q   <= '0;
					opb_q   <= dev2_mag;
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					opa_q  <= hi_next >> 1;
					opb_q  <= {hi_next[0], opb_q[DATA_WIDTH:1]};
					step_q <= step_q + 1'b1;
					if (step_last) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (acc_fire) begin
						m2_q     <= m2_new;
						ocount_q <= cnt_q;
						omean_q  <= mean_q;
						om2_q    <= m2_new;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign data.ready        = (state_q == ST_IDLE);
	assign result.valid      = ovalid_q;
	assign result.count      = ocount_q;
	assign result.mean       = omean_q;
	assign result.sq_dev_sum = om2_q;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !data.ready)
		else $error("sample taken while a sample was in progress");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != '0))
		else $error("division by zero count");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.count != '0))
		else $error("result with zero count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.sq_dev_sum)))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
